FILE: design/llm_pkg.sv
// Shared types, constants and helpers of the linked-list manager.
package llm_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;

    // Wide enough to compare a position against the element count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_POS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } rsp_t;

    // Lowest-numbered free node.
    function automatic logic [IDX_W-1:0] lowest_free(input logic [DEPTH-1:0] map);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (map[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Sign-extend a stored word from DATA_WIDTH and fit it to the data field.
    function automatic logic [DATA_W-1:0] data_out(input logic [DATA_WIDTH-1:0] stored);
        return DATA_W'(signed'(stored));
    endfunction

endpackage

FILE: design/llm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module llm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/linked_list_manager.sv
// Top level of the linked-list manager: sequencer, list registers and node stores.
//
// One request word on req (valid/stall) carries one operation: append a value at
// the tail, delete the head, delete the tail, delete a 1-based position, or
// traverse. Every operation answers with one response word on rsp (valid/stall),
// except traverse, which sends one word per element from head to tail with last
// set on the final one (an empty list still gives a single word).
// req_stall is high from the cycle after a word is taken until its final
// response word has been loaded into the output register, so one operation is
// in flight at a time. The deletes at the tail or at a position and traverse
// walk the links one node read a cycle through the registered read port of
// the link store; traverse pauses the walk while the output register is held.
// Reset empties the list (every node free, head, tail and count zero) at once;
// the node stores themselves are not cleared and need no clearing pass.
// When the receiver stalls, the response word holds in the output register and
// the sequencer waits before loading the next; traverse resumes where it paused.
module linked_list_manager (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  llm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output llm_pkg::rsp_t rsp
);

    import llm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_LINK     = 8'b0000_0100,
        S_DEL_HEAD = 8'b0000_1000,
        S_WALK     = 8'b0001_0000,
        S_UNLINK   = 8'b0010_0000,
        S_TRAV     = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DEPTH-1:0]     free_reg, free_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Working registers of the current operation
    logic [OP_W-1:0]      op_reg, op_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     alloc_reg, alloc_next;
    logic [IDX_W-1:0]     target_reg, target_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    rsp_t                 rsp_reg, rsp_next;

    // Store ports
    logic [IDX_W-1:0]      rd_addr;
    logic                  val_we;
    logic [IDX_W-1:0]      val_waddr;
    logic [DATA_WIDTH-1:0] val_wdata;
    logic [DATA_WIDTH-1:0] val_rdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [IDX_W-1:0]      link_wdata;
    logic [IDX_W-1:0]      link_rdata;

    logic                  out_free;
    logic [IDX_W-1:0]      free_idx;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      count_cmp;

    llm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    llm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The output register can take a word when empty or being emptied now.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign free_idx  = lowest_free(free_reg);
    assign pos_cmp   = CMP_W'(pos_reg);
    assign count_cmp = CMP_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        alloc_next     = alloc_reg;
        target_next    = target_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;

        rd_addr    = cur_reg;
        val_we     = 1'b0;
        val_waddr  = free_idx;
        val_wdata  = DATA_WIDTH'($unsigned(value_reg));
        link_we    = 1'b0;
        link_waddr = free_idx;
        link_wdata = '0;

        // Drop a delivered word; a newly loaded word overrides below.
        if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    value_next = req.value;
                    pos_next   = req.position;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Start a read of the head node for whichever walk follows.
                rd_addr     = head_reg;
                cur_next    = head_reg;
                steps_next  = '0;
                status_next = ST_OK;
                state_next  = S_RESP;
                unique case (op_reg)
                    OP_APPEND:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            val_we              = 1'b1;
                            link_we             = 1'b1;
                            free_next[free_idx] = 1'b0;
                            alloc_next          = free_idx;
                            if (count_reg == '0)
                            begin
                                head_next  = free_idx;
                                tail_next  = free_idx;
                                count_next = CNT_W'(1);
                            end
                            else
                            begin
                                state_next = S_LINK;
                            end
                        end
                    end
                    OP_DEL_HEAD:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_DEL_HEAD;
                        end
                    end
                    OP_DEL_TAIL:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (count_reg == CNT_W'(1))
                        begin
                            state_next = S_DEL_HEAD;
                        end
                        else
                        begin
                            steps_next = count_reg - CNT_W'(2);
                            state_next = S_WALK;
                        end
                    end
                    OP_DEL_POS:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (pos_cmp == '0 || pos_cmp > count_cmp)
                        begin
                            status_next = ST_NO_POS;
                        end
                        else if (pos_cmp == CMP_W'(1))
                        begin
                            state_next = S_DEL_HEAD;
                        end
                        else
                        begin
                            steps_next = CNT_W'(pos_cmp - CMP_W'(2));
                            state_next = S_WALK;
                        end
                    end
                    OP_TRAVERSE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_TRAV;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_LINK:
            begin
                link_we     = 1'b1;
                link_waddr  = tail_reg;
                link_wdata  = alloc_reg;
                tail_next   = alloc_reg;
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_OK;
                state_next  = S_RESP;
            end

            S_DEL_HEAD:
            begin
                head_next           = link_rdata;
                free_next[head_reg] = 1'b1;
                count_next          = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                status_next = ST_OK;
                state_next  = S_RESP;
            end

            S_WALK:
            begin
                // link_rdata holds the link of cur_reg.
                if (steps_reg == '0)
                begin
                    if (op_reg == OP_DEL_TAIL)
                    begin
                        free_next[tail_reg] = 1'b1;
                        tail_next           = cur_reg;
                        count_next          = count_reg - CNT_W'(1);
                        status_next         = ST_OK;
                        state_next          = S_RESP;
                    end
                    else
                    begin
                        target_next = link_rdata;
                        rd_addr     = link_rdata;
                        state_next  = S_UNLINK;
                    end
                end
                else
                begin
                    cur_next   = link_rdata;
                    rd_addr    = link_rdata;
                    steps_next = steps_reg - CNT_W'(1);
                end
            end

            S_UNLINK:
            begin
                // Bypass the target: its successor is on link_rdata.
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = link_rdata;
                if (target_reg == tail_reg)
                begin
                    tail_next = cur_reg;
                end
                free_next[target_reg] = 1'b1;
                count_next            = count_reg - CNT_W'(1);
                status_next           = ST_OK;
                state_next            = S_RESP;
            end

            S_TRAV:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status = ST_OK;
                    rsp_next.data   = data_out(val_rdata);
                    rsp_next.count  = COUNT_W'(count_reg);
                    rsp_next.last   = (steps_reg == count_reg - CNT_W'(1));
                    if (steps_reg == count_reg - CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = link_rdata;
                        rd_addr    = link_rdata;
                        steps_next = steps_reg + CNT_W'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.data   = '0;
                    rsp_next.count  = COUNT_W'(count_reg);
                    rsp_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        alloc_reg  <= alloc_next;
        target_reg <= target_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the linked-list manager: directed and random list operations.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import llm_pkg::*;

    // Give up after this many cycles in which neither channel moves a word.
    localparam int QUIET_LIMIT  = 4000;
    // Allow the longest operation to finish, with a margin.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    linked_list_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Request words waiting for the driver, and response words the block still owes.
    req_t queued_req[$];
    rsp_t owed_rsp[$];

    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic word_taken   = 1'b0;
    int   quiet_cycles = 0;
    int   mismatches   = 0;

    // Shadow of the list as the block should hold it.
    logic [DATA_WIDTH-1:0] node_val [DEPTH];
    logic [IDX_W-1:0]      node_next [DEPTH];
    logic [IDX_W-1:0]      head_at;
    logic [IDX_W-1:0]      tail_at;
    logic [DEPTH-1:0]      free_nodes;
    int                    list_len;

    // Length the generator expects the list to have once every queued word is done,
    // and the length it is currently steering towards.
    int plan_len  = 0;
    int plan_goal = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // List shadow
    // ------------------------------------------------------------------

    // Queue one owed response word; count always reflects the list after the operation.
    function automatic void owe(input logic [STATUS_W-1:0] st,
                                input logic [DATA_WIDTH-1:0] stored,
                                input logic last_word);
        rsp_t w;
        w.status = st;
        w.data   = DATA_W'($signed(stored));
        w.count  = COUNT_W'(list_len);
        w.last   = last_word;
        owed_rsp.push_back(w);
    endfunction

    // Follow the links from the head a given number of steps.
    function automatic logic [IDX_W-1:0] node_after(input int steps);
        logic [IDX_W-1:0] at;
        at = head_at;
        for (int i = 0; i < steps; i++)
            at = node_next[at];
        return at;
    endfunction

    // Drop the head node; an emptied list parks head and tail at node zero.
    function automatic void unlink_head();
        logic [IDX_W-1:0] old;
        old = head_at;
        head_at = node_next[old];
        free_nodes[old] = 1'b1;
        list_len--;
        if (list_len == 0)
        begin
            head_at = '0;
            tail_at = '0;
        end
    endfunction

    // Advance the shadow by one accepted request word and queue what it must answer.
    function automatic void apply_list_op(input req_t w);
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] victim;
        int               pos;
        int               k;
        pos = int'(w.position);
        case (w.operation)
            OP_APPEND:
            begin
                if (list_len >= DEPTH)
                    owe(ST_FULL, '0, 1'b1);
                else
                begin
                    // Take the lowest-numbered free node.
                    k = 0;
                    while (!free_nodes[k])
                        k++;
                    slot = IDX_W'(k);
                    free_nodes[slot] = 1'b0;
                    node_val[slot]   = w.value[DATA_WIDTH-1:0];
                    node_next[slot]  = '0;
                    if (list_len == 0)
                        head_at = slot;
                    else
                        node_next[tail_at] = slot;
                    tail_at = slot;
                    list_len++;
                    owe(ST_OK, '0, 1'b1);
                end
            end
            OP_DEL_HEAD:
            begin
                if (list_len == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                begin
                    unlink_head();
                    owe(ST_OK, '0, 1'b1);
                end
            end
            OP_DEL_TAIL:
            begin
                if (list_len == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (list_len == 1)
                        unlink_head();
                    else
                    begin
                        prev = node_after(list_len - 2);
                        free_nodes[tail_at] = 1'b1;
                        tail_at = prev;
                        list_len--;
                    end
                    owe(ST_OK, '0, 1'b1);
                end
            end
            OP_DEL_POS:
            begin
                if (list_len == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else if (pos < 1 || pos > list_len)
                    owe(ST_NO_POS, '0, 1'b1);
                else
                begin
                    if (pos == 1)
                        unlink_head();
                    else
                    begin
                        prev   = node_after(pos - 2);
                        victim = node_next[prev];
                        node_next[prev] = node_next[victim];
                        if (victim == tail_at)
                            tail_at = prev;
                        free_nodes[victim] = 1'b1;
                        list_len--;
                    end
                    owe(ST_OK, '0, 1'b1);
                end
            end
            OP_TRAVERSE:
            begin
                if (list_len == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                begin
                    slot = head_at;
                    for (int i = 0; i < list_len; i++)
                    begin
                        owe(ST_OK, node_val[slot], i == list_len - 1);
                        slot = node_next[slot];
                    end
                end
            end
            // Unused codes leave the list alone and answer once.
            default: owe(ST_OK, '0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Lean on the sign boundary, zero and all ones; otherwise any 32-bit value.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = {1'b1, {(VALUE_W - 1){1'b0}}};
            1:       v = {1'b0, {(VALUE_W - 1){1'b1}}};
            2:       v = '0;
            3:       v = '1;
            default: v = VALUE_W'($urandom);
        endcase
        return v;
    endfunction

    // Queue one request word and track the length the list will have after it.
    function automatic void queue_word(input logic [OP_W-1:0] op,
                                       input logic [VALUE_W-1:0] value,
                                       input int pos);
        req_t w;
        w.operation = op;
        w.value     = value;
        w.position  = POS_W'(pos);
        queued_req.push_back(w);
        case (op) inside
            OP_APPEND:
            begin
                if (plan_len < DEPTH)
                    plan_len++;
                else
                    // Full store reached: turn back and drain part of the list.
                    plan_goal = $urandom_range(0, DEPTH - 1);
            end
            OP_DEL_HEAD, OP_DEL_TAIL:
            begin
                if (plan_len > 0)
                    plan_len--;
            end
            OP_DEL_POS:
            begin
                if (pos >= 1 && pos <= plan_len)
                    plan_len--;
            end
            default: ;
        endcase
    endfunction

    // Steer the list towards a goal length with valid operations, then pick a new goal.
    // A small share of words is pure noise: any code, any position.
    function automatic void queue_random_ops(input int n);
        logic [OP_W-1:0] op;
        int              pos;
        int              roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            pos  = $urandom_range(0, 2**POS_W - 1);
            if (roll < 8)
                op = OP_W'($urandom_range(0, 2**OP_W - 1));
            else if (roll < 20 || plan_len == plan_goal)
            begin
                op = OP_TRAVERSE;
                if (plan_len == plan_goal)
                begin
                    case ($urandom_range(0, 4))
                        0:       plan_goal = 0;
                        1:       plan_goal = DEPTH + 1;
                        default: plan_goal = $urandom_range(1, DEPTH);
                    endcase
                end
            end
            else if (plan_len < plan_goal)
                op = OP_APPEND;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_DEL_HEAD;
                    1:       op = OP_DEL_TAIL;
                    default: op = OP_DEL_POS;
                endcase
                // Mostly a live position; now and then whatever the field allows.
                if ($urandom_range(0, 7) != 0)
                    pos = $urandom_range(1, plan_len);
            end
            queue_word(op, random_value(), pos);
        end
    endfunction

    // Set the idling mix, queue the words and hold further stimulus until the
    // block has sent every owed word.
    task automatic run_phase(input int send_idle, input int rsp_hold, input int n);
        idle_pct  = send_idle;
        stall_pct = rsp_hold;
        queue_random_ops(n);
        while (queued_req.size() != 0 || req_valid || owed_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present a new request word only once the last one has been taken,
    // and hold it unchanged while stalled. Drive everything at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || word_taken)
        begin
            if (queued_req.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                req       <= queued_req.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each response word against the oldest owed word, then
    // advance the shadow for any request word taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                    report_mismatch($sformatf(
                        "unexpected word status %0d data %0d count %0d last %0b",
                        rsp.status, rsp.data, rsp.count, rsp.last));
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  rsp.status, want.status));
                    if (rsp.data !== want.data)
                        report_mismatch($sformatf("data %0d, wanted %0d",
                                                  rsp.data, want.data));
                    if (rsp.count !== want.count)
                        report_mismatch($sformatf("count %0d, wanted %0d",
                                                  rsp.count, want.count));
                    if (rsp.last !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b",
                                                  rsp.last, want.last));
                end
            end
            if (req_valid && !req_stall)
                apply_list_op(req);
        end
        word_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: a stuck handshake ends the run.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        // Initialise the shadow to the reset state: empty list, every node free.
        foreach (node_val[i])
        begin
            node_val[i]  = '0;
            node_next[i] = '0;
        end
        head_at    = '0;
        tail_at    = '0;
        list_len   = 0;
        free_nodes = '1;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation on the empty list, the sign extremes,
        // rejected positions, deletion in the middle and at the tail,
        // a single-element list and the unused codes.
        queue_word(OP_TRAVERSE, random_value(), 0);
        queue_word(OP_DEL_HEAD, random_value(), 0);
        queue_word(OP_DEL_TAIL, random_value(), 0);
        queue_word(OP_DEL_POS, random_value(), 5);
        queue_word(OP_DEL_POS, random_value(), 0);
        queue_word(OP_APPEND, {1'b0, {(VALUE_W - 1){1'b1}}}, 0);
        queue_word(OP_APPEND, {1'b1, {(VALUE_W - 1){1'b0}}}, 2**POS_W - 1);
        queue_word(OP_APPEND, '0, 0);
        queue_word(OP_APPEND, '1, 0);
        queue_word(OP_TRAVERSE, random_value(), 0);
        queue_word(OP_DEL_POS, random_value(), 0);
        queue_word(OP_DEL_POS, random_value(), 5);
        queue_word(OP_DEL_POS, random_value(), 2**POS_W - 1);
        queue_word(OP_DEL_POS, random_value(), 2);
        // Remove the tail through its position, then append behind the new tail.
        queue_word(OP_DEL_POS, random_value(), 3);
        queue_word(OP_APPEND, random_value(), 0);
        queue_word(OP_DEL_TAIL, random_value(), 0);
        queue_word(OP_DEL_HEAD, random_value(), 0);
        queue_word(OP_TRAVERSE, random_value(), 0);
        for (int c = OP_TRAVERSE + 1; c < 2**OP_W; c++)
            queue_word(OP_W'(c), random_value(), $urandom_range(0, 2**POS_W - 1));
        // Tail delete on a single-element list empties it.
        queue_word(OP_DEL_TAIL, random_value(), 0);
        queue_word(OP_TRAVERSE, random_value(), 0);
        run_phase(0, 0, 0);

        // Random: first phase fills the store past full, then free-running goals.
        plan_goal = DEPTH + 1;
        run_phase(0, 0, 55);
        run_phase(78, 0, 55);
        run_phase(0, 78, 55);
        run_phase(31, 31, 55);

        // Let any stray word show itself before deciding.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
